@@ hw/rtl/sliding_median_filter_core_defines.svh @@
// Assertion helpers used by the filter core RTL.
`ifndef SLIDING_MEDIAN_FILTER_CORE_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smf assertion failed");

`endif

@@ hw/rtl/smf_pkg.sv @@
package smf_pkg;

  localparam int unsigned WindowDef     = 15;
  localparam int unsigned SampleBitsDef = 16;

  // Window ring control: load shifts a new sample in, rotate turns the ring by one entry.
  typedef struct packed {
    logic load;
    logic rotate;
  } win_ctrl_t;

endpackage

@@ hw/rtl/smf_window.sv @@
module smf_window #(
  parameter int unsigned WINDOW      = smf_pkg::WindowDef,
  parameter int unsigned SAMPLE_BITS = smf_pkg::SampleBitsDef,
  localparam int unsigned RankBits   = $clog2(WINDOW)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smf_pkg::win_ctrl_t            ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [RankBits-1:0]           rank_i,
  output logic signed [SAMPLE_BITS-1:0] head_value_o,
  output logic [RankBits-1:0]           head_rank_o
);

  // Entry 0 is the newest sample; the oldest sits at the head (last entry).
  logic signed [SAMPLE_BITS-1:0] val_q  [WINDOW];
  logic [RankBits-1:0]           rank_q [WINDOW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // all zeros; any permutation of ranks is a valid ordering of equal values
      for (int i = 0; i < WINDOW; i++) begin
        val_q[i]  <= '0;
        rank_q[i] <= RankBits'(WINDOW - 1 - i);
      end
    end else if (ctrl_i.load) begin
      val_q[0]  <= sample_i;
      rank_q[0] <= rank_i;
      for (int i = 1; i < WINDOW; i++) begin
        val_q[i]  <= val_q[i-1];
        rank_q[i] <= rank_q[i-1];
      end
    end else if (ctrl_i.rotate) begin
      val_q[0]  <= val_q[WINDOW-1];
      rank_q[0] <= rank_i;
      for (int i = 1; i < WINDOW; i++) begin
        val_q[i]  <= val_q[i-1];
        rank_q[i] <= rank_q[i-1];
      end
    end
  end

  assign head_value_o = val_q[WINDOW-1];
  assign head_rank_o  = rank_q[WINDOW-1];

endmodule

@@ hw/rtl/smf_rank_alu.sv @@
module smf_rank_alu #(
  parameter int unsigned WINDOW      = smf_pkg::WindowDef,
  parameter int unsigned SAMPLE_BITS = smf_pkg::SampleBitsDef,
  localparam int unsigned RankBits   = $clog2(WINDOW)
) (
  input  logic signed [SAMPLE_BITS-1:0] head_value_i,
  input  logic [RankBits-1:0]           head_rank_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [RankBits-1:0]           old_rank_i,
  input  logic [RankBits-1:0]           cnt_i,
  input  logic                          is_new_i,
  output logic [RankBits-1:0]           rank_o,
  output logic                          below_o
);

  logic dec;
  logic below;

  // The retired sample's slot closes; the new sample sorts above equal values.
  assign dec   = head_rank_i > old_rank_i;
  assign below = head_value_i <= sample_i;

  always_comb begin
    rank_o  = head_rank_i;
    below_o = 1'b0;
    if (is_new_i) begin
      rank_o = cnt_i;
    end else begin
      below_o = below;
      if (below && dec) begin
        rank_o = head_rank_i - RankBits'(1);
      end else if (!below && !dec) begin
        rank_o = head_rank_i + RankBits'(1);
      end
    end
  end

endmodule

@@ hw/rtl/sliding_median_filter_core.sv @@
// Running median over the last WINDOW signed samples; the window reads as zeros after
// reset. Each request carries one sample and yields one median, the mean of the two
// middle values (floored) when WINDOW is even. Every sample has a rank in the window;
// a single comparator walks the ring once per request to update the ranks, and a final
// halving add forms the median; no new request is taken during the sweep. The next
// request is taken in the cycle the result is written to the output register.
module sliding_median_filter_core #(
  parameter int unsigned WINDOW      = smf_pkg::WindowDef,
  parameter int unsigned SAMPLE_BITS = smf_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] median_o
);

  import smf_pkg::*;

`include "sliding_median_filter_core_defines.svh"

  localparam int unsigned RankBits           = $clog2(WINDOW);
  localparam logic [RankBits-1:0] LastStep   = RankBits'(WINDOW - 1);
  localparam logic [RankBits-1:0] LoRank     = RankBits'((WINDOW - 1) / 2);
  localparam logic [RankBits-1:0] HiRank     = RankBits'(WINDOW / 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_MEAN
  } state_e;

  state_e                        state_q;
  logic [RankBits-1:0]           step_q;
  logic [RankBits-1:0]           cnt_q;
  logic [RankBits-1:0]           old_rank_q;
  logic signed [SAMPLE_BITS-1:0] new_q;
  logic signed [SAMPLE_BITS-1:0] lo_q;
  logic signed [SAMPLE_BITS-1:0] hi_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] median_q;

  win_ctrl_t                     win_ctrl;
  logic signed [SAMPLE_BITS-1:0] head_value;
  logic [RankBits-1:0]           head_rank;
  logic [RankBits-1:0]           upd_rank;
  logic                          below;
  logic                          is_new;
  logic                          out_free;
  logic                          accept;
  logic signed [SAMPLE_BITS:0]   mid_sum;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_MEAN) && out_free));
  assign accept     = in_valid_i && !in_stall_o;
  assign is_new     = step_q == LastStep;

  assign win_ctrl.load   = accept;
  assign win_ctrl.rotate = state_q == ST_SWEEP;

  smf_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (win_ctrl),
    .sample_i     (sample_i),
    .rank_i       (upd_rank),
    .head_value_o (head_value),
    .head_rank_o  (head_rank)
  );

  smf_rank_alu #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rank_alu (
    .head_value_i (head_value),
    .head_rank_i  (head_rank),
    .sample_i     (new_q),
    .old_rank_i   (old_rank_q),
    .cnt_i        (cnt_q),
    .is_new_i     (is_new),
    .rank_o       (upd_rank),
    .below_o      (below)
  );

  // floored mean; equals the middle value when both picks coincide
  assign mid_sum = {lo_q[SAMPLE_BITS-1], lo_q} + {hi_q[SAMPLE_BITS-1], hi_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      old_rank_q  <= '0;
      new_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
      median_q    <= '0;
    end else begin
      if ((state_q == ST_MEAN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (below) begin
            cnt_q <= cnt_q + RankBits'(1);
          end
          if (upd_rank == LoRank) begin
            lo_q <= head_value;
          end
          if (upd_rank == HiRank) begin
            hi_q <= head_value;
          end
          if (is_new) begin
            state_q <= ST_MEAN;
          end
          step_q <= step_q + RankBits'(1);
        end
        ST_MEAN: begin
          if (out_free) begin
            median_q <= mid_sum[SAMPLE_BITS:1];
            state_q  <= accept ? ST_SWEEP : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // request taken: the oldest sample leaves, its rank slot opens
      if (accept) begin
        step_q     <= '0;
        cnt_q      <= '0;
        old_rank_q <= head_rank;
        new_q      <= sample_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  `SMF_ASSERT_NEXT(a_accept_starts_sweep, clk_i, rst_ni, accept,
                   (state_q == ST_SWEEP) && (step_q == '0))
  `SMF_ASSERT_IMPL(a_cnt_bounded, clk_i, rst_ni, state_q == ST_SWEEP, cnt_q <= step_q)
  `SMF_ASSERT_IMPL(a_mid_ordered, clk_i, rst_ni, state_q == ST_MEAN, lo_q <= hi_q)
  `SMF_ASSERT_IMPL(a_result_from_mean, clk_i, rst_ni, $rose(out_valid_q),
                   $past(state_q) == ST_MEAN)

endmodule

@@ test/tb_sliding_median_filter_core.sv @@
`timescale 1ns / 1ps

module tb_sliding_median_filter_core;

  localparam int unsigned W  = smf_pkg::WindowDef;
  localparam int unsigned SB = smf_pkg::SampleBitsDef;
  localparam int unsigned HoldCycles = 40 * W;
  localparam int unsigned RandomItems = 2000;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct packed {
    sample_t     sample;
    int unsigned count;
    bit          typed;
    sample_t     median;
  } stim_row_t;

  // Median is only typed in where the window is still mostly reset zeros.
  localparam stim_row_t DirectedRows[6] = '{
    '{16'sh7fff, 1,  1'b1, 16'sh0000},
    '{16'sh8000, 1,  1'b1, 16'sh0000},
    '{16'sh0001, 1,  1'b1, 16'sh0000},
    '{16'shffff, 1,  1'b1, 16'sh0000},
    '{16'sh7fff, 12, 1'b0, 16'sh0000},  // window fills with ties at full scale
    '{16'sh8000, 8,  1'b0, 16'sh0000}   // majority swings to negative full scale
  };

  logic    clk = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  sample_t sample_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  sample_t median_o;

  sample_t     recent_samples [W];
  sample_t     median_due [$];
  int unsigned mismatch_count = 0;
  bit          no_idle = 1'b0;
  bit          hold_receiver = 1'b0;

  sliding_median_filter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .median_o    (median_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Shift the new sample in, rank the window and take the middle.
  function automatic sample_t next_median(sample_t s);
    sample_t             ranked [W];
    sample_t             key;
    int                  j;
    logic signed [SB:0]  pair_sum;
    for (int i = W - 1; i > 0; i--) recent_samples[i] = recent_samples[i-1];
    recent_samples[0] = s;
    for (int i = 0; i < W; i++) ranked[i] = recent_samples[i];
    for (int i = 1; i < W; i++) begin
      key = ranked[i];
      j = i - 1;
      while (j >= 0 && ranked[j] > key) begin
        ranked[j+1] = ranked[j];
        j--;
      end
      ranked[j+1] = key;
    end
    if (W % 2 == 0) begin
      pair_sum = ranked[W/2] + ranked[W/2-1];
      return sample_t'(pair_sum >>> 1);
    end
    return ranked[(W-1)/2];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic sample_t draw_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return sample_t'($urandom);
    if (pick < 60) return sample_t'(int'($urandom_range(16)) - 8);
    if (pick < 75) return $urandom_range(1) ? sample_t'(16'sh7fff) : sample_t'(16'sh8000);
    // reuse a value already in the window so ties are common
    return recent_samples[$urandom_range(W - 1)];
  endfunction

  task automatic send_sample(sample_t s, bit typed, sample_t typed_median);
    sample_t     predicted;
    int unsigned gap;
    @(negedge clk);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk); while (in_stall_o);
    predicted = next_median(s);
    median_due.push_back(typed ? typed_median : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // receiver stall pattern, with one long hold-off on request
  always begin
    int unsigned gap;
    @(negedge clk);
    if (hold_receiver) begin
      out_stall_i <= 1'b1;
      repeat (HoldCycles) @(negedge clk);
      hold_receiver = 1'b0;
    end else begin
      gap = pick_gap();
      out_stall_i <= (gap > 0);
      if (gap > 1) repeat (gap - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (median_due.size() == 0) begin
        $error("median: unexpected result %0d", median_o);
        mismatch_count++;
      end else if (median_o !== median_due[0]) begin
        $error("median: expected %0d, actual %0d", median_due[0], median_o);
        mismatch_count++;
        void'(median_due.pop_front());
      end else begin
        void'(median_due.pop_front());
      end
    end
  end

  initial begin
    int unsigned drain_cycles;
    for (int i = 0; i < W; i++) recent_samples[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (DirectedRows[r]) begin
      for (int k = 0; k < DirectedRows[r].count; k++) begin
        send_sample(DirectedRows[r].sample, DirectedRows[r].typed, DirectedRows[r].median);
      end
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 300) no_idle = 1'b1;
      if (n == 500) no_idle = 1'b0;
      if (n == 800) hold_receiver = 1'b1;  // sender keeps offering requests meanwhile
      if (n == 1200) begin
        @(negedge clk);
        in_valid_i <= 1'b0;
        while (median_due.size() != 0) @(posedge clk);
      end
      send_sample(draw_sample(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid_i <= 1'b0;
    drain_cycles = 0;
    while (median_due.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (4 * (W + 1)) @(posedge clk);
    if (median_due.size() != 0) begin
      $error("median: %0d expected results never arrived", median_due.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/smf_pkg.sv
hw/rtl/smf_window.sv
hw/rtl/smf_rank_alu.sv
hw/rtl/sliding_median_filter_core.sv
test/tb_sliding_median_filter_core.sv
